// ===== hw/rtl/stfem_pkg.sv =====
// Shared types and constants for the span to file extent mapper.
`default_nettype none

package stfem_pkg;

    localparam int MAX_FILES = 16;
    localparam int OFF_W     = 48;
    localparam int LEN_W     = 24;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int CUR_W     = OFF_W + 1;
    localparam int SUM_W     = OFF_W + 2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MAP  = 1'b1;

    localparam logic [2:0] ADDR_FILE_COUNT = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] entry_index;
        logic [OFF_W-1:0] entry_start;
        logic [OFF_W-1:0] entry_length;
        logic [OFF_W-1:0] request_offset;
        logic [LEN_W-1:0] request_length;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] file_index;
        logic [OFF_W-1:0] extent_offset;
        logic [LEN_W-1:0] segment_length;
        logic [LEN_W-1:0] buffer_offset;
        logic             no_overlap;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic             valid;
        logic [CUR_W-1:0] cur;
        logic [LEN_W-1:0] remaining;
        logic [LEN_W-1:0] boff;
    } token_t;

    typedef struct packed {
        logic             emit;
        logic             stop;
        logic [IDX_W-1:0] file_index;
        logic [OFF_W-1:0] extent_offset;
        logic [LEN_W-1:0] segment_length;
        logic [LEN_W-1:0] buffer_offset;
    } cell_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stfem_cell.sv =====
// One extent cell: holds one table entry and clips the passing walk token against it.
`default_nettype none

module stfem_cell
    import stfem_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic             en,
    input  wire token_t           token_in,
    input  wire logic             wr_en,
    input  wire logic [OFF_W-1:0] wr_start,
    input  wire logic [OFF_W-1:0] wr_length,
    output token_t                token_out,
    output cell_res_t             res
);

    token_t           token_reg;
    logic [OFF_W-1:0] start_reg;
    logic [OFF_W-1:0] length_reg;

    logic [SUM_W-1:0] fend;
    logic [SUM_W-1:0] wend;
    logic [SUM_W-1:0] rs;
    logic [SUM_W-1:0] re;
    logic [SUM_W-1:0] seg_full;
    logic [SUM_W-1:0] foff_full;
    logic             rem_zero;
    logic             skip;
    logic             halt;
    logic             emit;
    logic             stop_here;
    logic             last_cell;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else if (en)
        begin
            token_reg <= token_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_reg  <= wr_start;
            length_reg <= wr_length;
        end
    end

    always_comb
    begin
        fend      = SUM_W'(start_reg) + SUM_W'(length_reg);
        wend      = SUM_W'(token_reg.cur) + SUM_W'(token_reg.remaining);
        rs        = (SUM_W'(token_reg.cur) > SUM_W'(start_reg)) ? SUM_W'(token_reg.cur)
                                                                : SUM_W'(start_reg);
        re        = (wend < fend) ? wend : fend;
        seg_full  = re - rs;
        foff_full = rs - SUM_W'(start_reg);
        rem_zero  = (token_reg.remaining == '0);
        skip      = (SUM_W'(token_reg.cur) >= fend);
        halt      = (wend <= SUM_W'(start_reg));
        emit      = token_reg.valid && !rem_zero && !skip && !halt && (seg_full != '0);
        stop_here = rem_zero || (!skip && halt);
        last_cell = ((CNT_W'(idx) + CNT_W'(1)) >= count);

        token_out.valid     = token_reg.valid && !stop_here && !last_cell;
        token_out.cur       = emit ? re[CUR_W-1:0] : token_reg.cur;
        token_out.remaining = emit ? (token_reg.remaining - seg_full[LEN_W-1:0])
                                   : token_reg.remaining;
        token_out.boff      = emit ? (token_reg.boff + seg_full[LEN_W-1:0])
                                   : token_reg.boff;

        res = '0;
        if (token_reg.valid)
        begin
            res.emit           = emit;
            res.stop           = stop_here || last_cell;
            res.file_index     = idx;
            res.extent_offset  = foff_full[OFF_W-1:0];
            res.segment_length = seg_full[LEN_W-1:0];
            res.buffer_offset  = token_reg.boff;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/span_to_file_extent_mapper.sv =====
// Top level of the span to file extent mapper: cell chain, result staging and register port.
//
// Usage: requests arrive on req_valid / req_stall / req, results leave on
// rsp_valid / rsp_stall / rsp. A load request (func = 0) writes one extent
// entry and returns nothing. A map request (func = 1) walks the entries
// 0 .. file_count-1 (file_count clamped to 16) through a chain of 16 cells,
// one cell per cycle while the walk is not paused by rsp_stall, and returns
// one result per overlapping segment, or one result with no_overlap set.
// The last result carries last. The final result is staged through the
// flush state, and the next request can be taken in the same cycle that
// it is on rsp. req_stall is high while a map request is in progress, so
// one request is worked at a time.
// Reset clears file_count, the walk and the result valid flags; extent
// entries are undefined until loaded. When rsp_stall is high while
// rsp_valid is set, the result stays on rsp and the walk pauses until it
// is taken.
// file_count is at byte address 0 of the register port; the user must
// write it only while the block is idle, which the block does not enforce.
`default_nettype none

module span_to_file_extent_mapper
    import stfem_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] file_count_reg;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             hold_valid_reg;
    logic             hold_valid_next;
    rsp_t             hold_reg;
    rsp_t             hold_next;

    logic             req_accept;
    logic             map_accept;
    logic             step;
    logic [CNT_W-1:0] count;
    token_t           token_in  [MAX_FILES];
    token_t           token_out [MAX_FILES];
    cell_res_t        cell_res  [MAX_FILES];
    cell_res_t        walk_res;
    rsp_t             seg_item;

    assign pready    = 1'b1;
    assign prdata    = 32'(file_count_reg);
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign req_accept = req_valid && !req_stall;
    assign map_accept = req_accept && (req.func == FUNC_MAP);
    assign step       = !rsp_valid_reg || !rsp_stall;
    assign count      = (file_count_reg > CNT_W'(MAX_FILES)) ? CNT_W'(MAX_FILES)
                                                             : file_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_count_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_FILE_COUNT))
        begin
            file_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    generate
        for (genvar g = 0; g < MAX_FILES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                always_comb
                begin
                    token_in[g].valid     = map_accept && (count != '0);
                    token_in[g].cur       = CUR_W'(req.request_offset);
                    token_in[g].remaining = req.request_length;
                    token_in[g].boff      = '0;
                end
            end
            else
            begin : g_body
                assign token_in[g] = token_out[g-1];
            end

            stfem_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (IDX_W'(g)),
                .count     (count),
                .en        (step || req_accept),
                .token_in  (token_in[g]),
                .wr_en     (req_accept && (req.func == FUNC_LOAD) &&
                            (req.entry_index == IDX_W'(g))),
                .wr_start  (req.entry_start),
                .wr_length (req.entry_length),
                .token_out (token_out[g]),
                .res       (cell_res[g])
            );
        end
    endgenerate

    always_comb
    begin
        walk_res = '0;
        for (int i = 0; i < MAX_FILES; i++)
        begin
            walk_res = cell_res_t'(walk_res | cell_res[i]);
        end
        seg_item.file_index     = walk_res.file_index;
        seg_item.extent_offset  = walk_res.extent_offset;
        seg_item.segment_length = walk_res.segment_length;
        seg_item.buffer_offset  = walk_res.buffer_offset;
        seg_item.no_overlap     = 1'b0;
        seg_item.last           = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        hold_reg <= hold_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;

        if (step)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (map_accept)
                begin
                    hold_valid_next = 1'b0;
                    state_next      = (count == '0) ? ST_FLUSH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (step)
                begin
                    if (walk_res.emit)
                    begin
                        if (hold_valid_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = hold_reg;
                            rsp_next.last  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_next       = seg_item;
                    end
                    if (walk_res.stop)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (step)
                begin
                    rsp_valid_next = 1'b1;
                    if (hold_valid_reg)
                    begin
                        rsp_next      = hold_reg;
                        rsp_next.last = 1'b1;
                    end
                    else
                    begin
                        rsp_next            = '0;
                        rsp_next.no_overlap = 1'b1;
                        rsp_next.last       = 1'b1;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
